/* hdl/swam_pkg.sv */
// ----------------------------------------------------------------------------
// swam_pkg
// Shared constants, operation codes and stage records for the sliding window
// anagram matcher.
// ----------------------------------------------------------------------------
package swam_pkg;

    localparam int MAX_WINDOW_DEF   = 4096;
    localparam int FIRST_SYMBOL_DEF = 63;
    localparam int LAST_SYMBOL_DEF  = 125;

    localparam int OP_W  = 2;
    localparam int SYM_W = 8;
    localparam int POS_W = 32;

    localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // item decoded by the front end, handed to the histogram stages
    typedef struct packed {
        logic             clear;
        logic             pat_take;
        logic             txt_acc;
        logic             retire;
        logic             match_elig;
        logic             full;
        logic [POS_W-1:0] start;
        logic             overflow;
        logic [SYM_W-1:0] sym;
    } swam_item_t;

    typedef struct packed {
        logic             full;
        logic             is_match;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] total;
        logic             overflow;
    } swam_result_t;

endpackage

/* hdl/swam_ram.sv */
// ----------------------------------------------------------------------------
// swam_ram
// Generic single write port, single read port RAM with registered read data.
// Read returns the old contents when the same address is written.
// ----------------------------------------------------------------------------
module swam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/swam_front.sv */
// ----------------------------------------------------------------------------
// swam_front
// Input stage: pattern length, text position, overflow flag and the window
// ring. Decodes each transaction and reads back the symbol leaving the window.
// ----------------------------------------------------------------------------
module swam_front #(
    parameter int MAX_WINDOW = swam_pkg::MAX_WINDOW_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        take,
    input  logic [swam_pkg::OP_W-1:0]   op,
    input  logic [swam_pkg::SYM_W-1:0]  sym,
    output logic                        s1_valid,
    output swam_pkg::swam_item_t        s1_item,
    output logic [swam_pkg::SYM_W-1:0]  r_sym
);
    import swam_pkg::*;

    localparam int LW  = $clog2(MAX_WINDOW + 1);
    localparam int RAW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [LW-1:0] MW_L = LW'(MAX_WINDOW);

    logic [POS_W-1:0] pos_reg;
    logic [LW-1:0]    len_reg;
    logic [RAW-1:0]   wptr_reg;
    logic             ovf_reg;
    logic             s1_valid_reg;
    swam_item_t       item_reg;

    logic             is_pat, is_text, is_clear;
    logic             pat_open, pat_take, pat_over;
    logic             txt_on, txt_acc;
    logic [POS_W-1:0] len_ext, pos_new;
    logic [RAW-1:0]   wptr_inc, ring_raddr;
    logic [LW:0]      ptr_ext, len_ext1, rd_sum;
    swam_item_t       item_next;

    always_comb begin
        is_pat   = (op == OP_PATTERN);
        is_text  = (op == OP_TEXT);
        is_clear = (op == OP_CLEAR);
        pat_open = is_pat && (pos_reg == '0);
        pat_take = pat_open && (len_reg != MW_L);
        pat_over = pat_open && (len_reg == MW_L);
        txt_on   = is_text && (len_reg != '0);
        txt_acc  = txt_on && (pos_reg != '1);
        len_ext  = POS_W'(len_reg);
        pos_new  = txt_acc ? pos_reg + POS_W'(1) : pos_reg;

        ptr_ext  = (LW+1)'(wptr_reg);
        len_ext1 = (LW+1)'(len_reg);
        if (ptr_ext >= len_ext1) begin
            rd_sum = ptr_ext - len_ext1;
        end else begin
            rd_sum = ptr_ext + (LW+1)'(MAX_WINDOW) - len_ext1;
        end
        ring_raddr = rd_sum[RAW-1:0];
        wptr_inc   = (wptr_reg == RAW'(MAX_WINDOW - 1)) ? '0 : wptr_reg + RAW'(1);

        item_next.clear      = is_clear;
        item_next.pat_take   = pat_take;
        item_next.txt_acc    = txt_acc;
        item_next.retire     = txt_acc && (pos_reg >= len_ext);
        item_next.full       = txt_on && (pos_new >= len_ext);
        item_next.match_elig = txt_acc && item_next.full;
        item_next.start      = item_next.full ? pos_new - len_ext : '0;
        item_next.overflow   = !is_clear && (ovf_reg || pat_over);
        item_next.sym        = sym;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            len_reg      <= '0;
            wptr_reg     <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= take;
            end
            if (take) begin
                if (is_clear) begin
                    pos_reg  <= '0;
                    len_reg  <= '0;
                    wptr_reg <= '0;
                    ovf_reg  <= 1'b0;
                end else begin
                    if (pat_take) begin
                        len_reg <= len_reg + LW'(1);
                    end
                    if (pat_over) begin
                        ovf_reg <= 1'b1;
                    end
                    if (txt_acc) begin
                        pos_reg  <= pos_new;
                        wptr_reg <= wptr_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    // window ring, read-old on a full-length window
    swam_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (take && txt_acc),
        .waddr (wptr_reg),
        .wdata (sym),
        .re    (adv),
        .raddr (ring_raddr),
        .rdata (r_sym)
    );

    assign s1_valid = s1_valid_reg;
    assign s1_item  = item_reg;

endmodule

/* hdl/swam_hist.sv */
// ----------------------------------------------------------------------------
// swam_hist
// Difference histogram: two count memories, each in two copies (window adds
// and pattern or retire subtracts), read in the first stage, updated in the
// second with one-deep write forwarding. Tracks nonzero bins and match count.
// ----------------------------------------------------------------------------
module swam_hist #(
    parameter int MAX_WINDOW   = swam_pkg::MAX_WINDOW_DEF,
    parameter int FIRST_SYMBOL = swam_pkg::FIRST_SYMBOL_DEF,
    parameter int LAST_SYMBOL  = swam_pkg::LAST_SYMBOL_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        report_mode,
    input  logic                        s1_valid,
    input  swam_pkg::swam_item_t        s1_item,
    input  logic [swam_pkg::SYM_W-1:0]  r_sym,
    output logic                        s2_valid,
    output swam_pkg::swam_result_t      result
);
    import swam_pkg::*;

    localparam int BINS = LAST_SYMBOL - FIRST_SYMBOL + 1;
    localparam int IW   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int DW   = $clog2(MAX_WINDOW + 1) + 1;
    localparam int NZW  = $clog2(BINS + 1);
    localparam logic [SYM_W-1:0] FIRST_S = SYM_W'(FIRST_SYMBOL);
    localparam logic [SYM_W-1:0] LAST_S  = SYM_W'(LAST_SYMBOL);

    // stage 1
    logic          s_in1, r_in1;
    logic [IW-1:0] s_idx1, r_idx1;

    // stage 2 registers
    logic          s2_valid_reg;
    swam_item_t    s2_item_reg;
    logic          s2_sin_reg, s2_rin_reg;
    logic [IW-1:0] s2_sidx_reg, s2_ridx_reg;

    // forwarding and valid bits
    logic          fa_en_reg, fd_en_reg;
    logic [IW-1:0] fa_addr_reg, fd_addr_reg;
    logic [DW-1:0] fa_data_reg, fd_data_reg;
    logic [BINS-1:0] va_reg, vd_reg;

    logic [NZW-1:0]   nz_reg;
    logic [POS_W-1:0] total_reg;
    logic             found_reg;

    // stage 2 logic
    logic [DW-1:0]    ras_rdata, rar_rdata, rds_rdata, rdr_rdata;
    logic [DW-1:0]    a_s, a_r, d_s, d_r;
    logic [DW-1:0]    diff_r0, diff_r1, diff_s0, diff_s1;
    logic             ret_eff, add_eff, dec_eff, same_bin, hit;
    logic [NZW-1:0]   nz_mid, nz_new;
    logic [POS_W-1:0] total_new;
    logic             a_we, d_we;
    logic [IW-1:0]    d_waddr;
    logic [DW-1:0]    a_wdata, d_wdata;

    always_comb begin
        s_in1  = (s1_item.sym >= FIRST_S) && (s1_item.sym <= LAST_S);
        r_in1  = (r_sym >= FIRST_S) && (r_sym <= LAST_S);
        s_idx1 = IW'(s1_item.sym - FIRST_S);
        r_idx1 = IW'(r_sym - FIRST_S);
    end

    swam_ram #(.WIDTH(DW), .DEPTH(BINS)) u_add_s (
        .aclk(aclk), .we(a_we), .waddr(s2_sidx_reg), .wdata(a_wdata),
        .re(adv), .raddr(s_idx1), .rdata(ras_rdata)
    );
    swam_ram #(.WIDTH(DW), .DEPTH(BINS)) u_add_r (
        .aclk(aclk), .we(a_we), .waddr(s2_sidx_reg), .wdata(a_wdata),
        .re(adv), .raddr(r_idx1), .rdata(rar_rdata)
    );
    swam_ram #(.WIDTH(DW), .DEPTH(BINS)) u_sub_s (
        .aclk(aclk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .re(adv), .raddr(s_idx1), .rdata(rds_rdata)
    );
    swam_ram #(.WIDTH(DW), .DEPTH(BINS)) u_sub_r (
        .aclk(aclk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .re(adv), .raddr(r_idx1), .rdata(rdr_rdata)
    );

    always_comb begin
        a_s = (fa_en_reg && fa_addr_reg == s2_sidx_reg) ? fa_data_reg :
              (va_reg[s2_sidx_reg] ? ras_rdata : '0);
        a_r = (fa_en_reg && fa_addr_reg == s2_ridx_reg) ? fa_data_reg :
              (va_reg[s2_ridx_reg] ? rar_rdata : '0);
        d_s = (fd_en_reg && fd_addr_reg == s2_sidx_reg) ? fd_data_reg :
              (vd_reg[s2_sidx_reg] ? rds_rdata : '0);
        d_r = (fd_en_reg && fd_addr_reg == s2_ridx_reg) ? fd_data_reg :
              (vd_reg[s2_ridx_reg] ? rdr_rdata : '0);

        ret_eff  = s2_item_reg.retire && s2_rin_reg;
        add_eff  = s2_item_reg.txt_acc && s2_sin_reg;
        dec_eff  = s2_item_reg.pat_take && s2_sin_reg;
        same_bin = ret_eff && (s2_ridx_reg == s2_sidx_reg);

        // retire first, then the new symbol
        diff_r0 = a_r - d_r;
        diff_r1 = diff_r0 - DW'(1);
        diff_s0 = same_bin ? diff_r1 : a_s - d_s;
        diff_s1 = add_eff ? diff_s0 + DW'(1) : diff_s0 - DW'(1);

        nz_mid = nz_reg;
        if (ret_eff) begin
            if (diff_r0 == '0) begin
                nz_mid = nz_reg + NZW'(1);
            end else if (diff_r1 == '0) begin
                nz_mid = nz_reg - NZW'(1);
            end
        end
        nz_new = nz_mid;
        if (add_eff || dec_eff) begin
            if (diff_s0 == '0) begin
                nz_new = nz_mid + NZW'(1);
            end else if (diff_s1 == '0) begin
                nz_new = nz_mid - NZW'(1);
            end
        end

        hit = s2_item_reg.match_elig && (nz_new == '0) && !(report_mode && found_reg);
        total_new = (hit && total_reg != '1) ? total_reg + POS_W'(1) : total_reg;

        a_we    = adv && s2_valid_reg && add_eff;
        a_wdata = a_s + DW'(1);
        d_we    = adv && s2_valid_reg && (ret_eff || dec_eff);
        d_waddr = ret_eff ? s2_ridx_reg : s2_sidx_reg;
        d_wdata = ret_eff ? d_r + DW'(1) : d_s + DW'(1);

        result.full     = s2_item_reg.full;
        result.is_match = hit;
        result.start    = s2_item_reg.start;
        result.total    = s2_item_reg.clear ? '0 : total_new;
        result.overflow = s2_item_reg.overflow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            fa_en_reg    <= 1'b0;
            fd_en_reg    <= 1'b0;
            va_reg       <= '0;
            vd_reg       <= '0;
            nz_reg       <= '0;
            total_reg    <= '0;
            found_reg    <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid;
            fa_en_reg    <= a_we;
            fd_en_reg    <= d_we;
            if (s2_valid_reg) begin
                if (s2_item_reg.clear) begin
                    va_reg    <= '0;
                    vd_reg    <= '0;
                    nz_reg    <= '0;
                    total_reg <= '0;
                    found_reg <= 1'b0;
                end else begin
                    if (a_we) begin
                        va_reg[s2_sidx_reg] <= 1'b1;
                    end
                    if (d_we) begin
                        vd_reg[d_waddr] <= 1'b1;
                    end
                    nz_reg    <= nz_new;
                    total_reg <= total_new;
                    if (hit) begin
                        found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= s1_item;
            s2_sin_reg  <= s_in1;
            s2_rin_reg  <= r_in1;
            s2_sidx_reg <= s_idx1;
            s2_ridx_reg <= r_idx1;
            fa_addr_reg <= s2_sidx_reg;
            fa_data_reg <= a_wdata;
            fd_addr_reg <= d_waddr;
            fd_data_reg <= d_wdata;
        end
    end

    assign s2_valid = s2_valid_reg;

endmodule

/* hdl/sliding_window_anagram_matcher_core.sv */
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher_core
// Streaming anagram search: a pattern is loaded symbol by symbol, then text
// symbols stream in and each one yields the status of the current window.
//
// s_ channel: one transaction per symbol, s_operation selects pattern load,
// text symbol or clear. m_ channel: exactly one result per input transaction,
// in order. cfg channel: writes report_mode, always ready; the user must write
// it only while idle, not enforced by the block. A result passes the front
// item, update and output registers. Throughput: one transaction per cycle,
// set by the histogram read-modify-write (one read stage, one update stage,
// one-deep write forwarding). When the receiver stalls, the pipeline holds as
// a whole; s_ready stays high as long as the update stage is empty, so one
// more input is taken while a finished result waits in the output register.
// Reset clears all control state at once; histogram bins are tracked by valid
// bits, so there is no clearing pass. The clear operation does the same at
// run time and keeps report_mode.
// ----------------------------------------------------------------------------
module sliding_window_anagram_matcher_core #(
    parameter int MAX_WINDOW   = swam_pkg::MAX_WINDOW_DEF,
    parameter int FIRST_SYMBOL = swam_pkg::FIRST_SYMBOL_DEF,
    parameter int LAST_SYMBOL  = swam_pkg::LAST_SYMBOL_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [swam_pkg::OP_W-1:0]   s_operation,
    input  logic [swam_pkg::SYM_W-1:0]  s_symbol,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_window_full,
    output logic                        m_is_match,
    output logic [swam_pkg::POS_W-1:0]  m_window_start,
    output logic [swam_pkg::POS_W-1:0]  m_match_total,
    output logic                        m_pattern_overflow
);
    import swam_pkg::*;

    logic           mode_reg;
    logic           m_valid_reg;
    swam_result_t   res_reg;
    logic           adv, take;
    logic           s1_valid, s2_valid;
    swam_item_t     s1_item;
    logic [SYM_W-1:0] r_sym;
    swam_result_t   result;

    assign adv       = !s2_valid || !m_valid_reg || m_ready;
    assign take      = s_valid && adv;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    swam_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .take     (take),
        .op       (s_operation),
        .sym      (s_symbol),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .r_sym    (r_sym)
    );

    swam_hist #(
        .MAX_WINDOW   (MAX_WINDOW),
        .FIRST_SYMBOL (FIRST_SYMBOL),
        .LAST_SYMBOL  (LAST_SYMBOL)
    ) u_hist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .report_mode (mode_reg),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .r_sym       (r_sym),
        .s2_valid    (s2_valid),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (adv && s2_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_valid) begin
            res_reg <= result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_window_full      = res_reg.full;
    assign m_is_match         = res_reg.is_match;
    assign m_window_start     = res_reg.start;
    assign m_match_total      = res_reg.total;
    assign m_pattern_overflow = res_reg.overflow;

endmodule

/* hdl/swam_checker.sv */
// ----------------------------------------------------------------------------
// swam_checker
// Port-level checks on the anagram matcher, bound to the top level.
// ----------------------------------------------------------------------------
module swam_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [swam_pkg::OP_W-1:0]   s_operation,
    input  logic [swam_pkg::SYM_W-1:0]  s_symbol,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_window_full,
    input  logic                        m_is_match,
    input  logic [swam_pkg::POS_W-1:0]  m_window_start,
    input  logic [swam_pkg::POS_W-1:0]  m_match_total,
    input  logic                        m_pattern_overflow
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_operation) && $stable(s_symbol))
        else $error("input changed while stalled");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_start)
            && $stable(m_match_total) && $stable(m_is_match)
            && $stable(m_window_full) && $stable(m_pattern_overflow))
        else $error("result changed while stalled");

    // a flagged match needs a full window and a nonzero count
    a_match_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_match |-> m_window_full && (m_match_total != '0))
        else $error("match without full window");

    // no window, no start position
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_full |-> m_window_start == '0)
        else $error("start position without full window");

    // input only back-pressured by a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

endmodule

bind sliding_window_anagram_matcher_core swam_checker u_swam_checker (.*);

/* sim/sliding_window_anagram_matcher_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher_core_tb
// Self-checking bench for the streaming anagram search core. A scoreboard
// keeps its own symbol histogram, text ring and counters, predicts the
// status of every input transaction and compares it field by field with the
// result channel. Stimulus covers a directed opening, short random patterns
// with matching text in both report modes, noise and clears. Both channels
// idle and stall at random, including up to three long receiver hold-offs.
// ----------------------------------------------------------------------------

class anagram_scoreboard;
    bit          mode;
    int          hist [swam_pkg::FIRST_SYMBOL_DEF:swam_pkg::LAST_SYMBOL_DEF];
    int unsigned unequal_bins;
    bit [7:0]    recent_syms [swam_pkg::MAX_WINDOW_DEF];
    int unsigned win_len;
    bit [31:0]   text_count;
    bit [31:0]   hits;
    bit          hit_seen;
    bit          pattern_dropped;
    int unsigned checked;
    int unsigned errors;
    swam_pkg::swam_result_t expected_status [$];

    function new();
        mode    = 1'b0;
        checked = 0;
        errors  = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (hist[i]) hist[i] = 0;
        unequal_bins    = 0;
        win_len         = 0;
        text_count      = '0;
        hits            = '0;
        hit_seen        = 1'b0;
        pattern_dropped = 1'b0;
    endfunction

    function void shift_bin(bit [7:0] sym, int delta);
        int old_v;
        if (sym < swam_pkg::FIRST_SYMBOL_DEF || sym > swam_pkg::LAST_SYMBOL_DEF) return;
        old_v     = hist[sym];
        hist[sym] = old_v + delta;
        if (old_v == 0 && hist[sym] != 0) unequal_bins++;
        else if (old_v != 0 && hist[sym] == 0) unequal_bins--;
    endfunction

    function int unsigned pending();
        return expected_status.size();
    endfunction

    function void take_symbol(bit [1:0] op, bit [7:0] sym);
        swam_pkg::swam_result_t r;
        bit [31:0] p;
        bit        accept;
        r = '0;
        case (op)
            swam_pkg::OP_CLEAR: begin
                wipe();
            end
            swam_pkg::OP_PATTERN: begin
                if (text_count == 0) begin
                    if (win_len >= swam_pkg::MAX_WINDOW_DEF) begin
                        pattern_dropped = 1'b1;
                    end else begin
                        win_len++;
                        shift_bin(sym, -1);
                    end
                end
            end
            swam_pkg::OP_TEXT: begin
                if (win_len != 0) begin
                    p      = text_count;
                    accept = (p != '1);
                    if (accept) begin
                        if (p >= win_len)
                            shift_bin(recent_syms[(p - win_len) % swam_pkg::MAX_WINDOW_DEF], -1);
                        recent_syms[p % swam_pkg::MAX_WINDOW_DEF] = sym;
                        shift_bin(sym, 1);
                        p++;
                        text_count = p;
                    end
                    if (p >= win_len) begin
                        r.full  = 1'b1;
                        r.start = p - win_len;
                        if (accept && unequal_bins == 0 && !(mode && hit_seen)) begin
                            r.is_match = 1'b1;
                            hit_seen   = 1'b1;
                            if (hits != '1) hits++;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.total    = hits;
        r.overflow = pattern_dropped;
        expected_status.push_back(r);
    endfunction

    function void compare_status(swam_pkg::swam_result_t got);
        swam_pkg::swam_result_t want;
        checked++;
        if (expected_status.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
            return;
        end
        want = expected_status.pop_front();
        if (got.full !== want.full) begin
            $error("window_full: expected %0d, got %0d", want.full, got.full);
            errors++;
        end
        if (got.is_match !== want.is_match) begin
            $error("is_match: expected %0d, got %0d", want.is_match, got.is_match);
            errors++;
        end
        if (got.start !== want.start) begin
            $error("window_start: expected %0d, got %0d", want.start, got.start);
            errors++;
        end
        if (got.total !== want.total) begin
            $error("match_total: expected %0d, got %0d", want.total, got.total);
            errors++;
        end
        if (got.overflow !== want.overflow) begin
            $error("pattern_overflow: expected %0d, got %0d", want.overflow, got.overflow);
            errors++;
        end
    endfunction
endclass

module sliding_window_anagram_matcher_core_tb;

    localparam logic [swam_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PER_PASS = 165;
    localparam int LONG_HOLD       = 250;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [swam_pkg::OP_W-1:0]  s_operation;
    logic [swam_pkg::SYM_W-1:0] s_symbol;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_window_full;
    logic                       m_is_match;
    logic [swam_pkg::POS_W-1:0] m_window_start;
    logic [swam_pkg::POS_W-1:0] m_match_total;
    logic                       m_pattern_overflow;

    anagram_scoreboard      board = new();
    swam_pkg::swam_result_t seen;

    int          burst_left    = 0;
    logic [7:0]  alphabet [4];
    int          alpha_size    = 1;
    int          noise_level   = 0;
    int          random_sent   = 0;
    bit          pause_pending = 1'b1;
    bit          pass_modes [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    sliding_window_anagram_matcher_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_symbol           (s_symbol),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_window_full      (m_window_full),
        .m_is_match         (m_is_match),
        .m_window_start     (m_window_start),
        .m_match_total      (m_match_total),
        .m_pattern_overflow (m_pattern_overflow)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] sym);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 24);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_symbol    <= sym;
        do @(posedge aclk); while (!s_ready);
        board.take_symbol(op, sym);
        burst_left--;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic write_report_mode(input bit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.mode = value;
    endtask

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 99) < noise_level) return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alpha_size - 1)];
    endfunction

    // clear, mostly short pattern, then text from the same small alphabet mixed with stray operations
    task automatic run_episode();
        int len;
        int span;
        int roll;
        alpha_size  = $urandom_range(1, 4);
        noise_level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : 0;
        foreach (alphabet[i])
            alphabet[i] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(63, 125));
        send_item(swam_pkg::OP_CLEAR, 8'($urandom));
        roll = $urandom_range(0, 19);
        len  = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            send_item(swam_pkg::OP_PATTERN, pick_symbol());
            random_sent++;
        end
        span = $urandom_range(4, 40) + len;
        for (int i = 0; i < span; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_item(OP_UNUSED, 8'($urandom));
            end else if (roll < 5) begin
                send_item(swam_pkg::OP_PATTERN, 8'($urandom));
            end else if (roll < 6) begin
                send_item(swam_pkg::OP_CLEAR, 8'($urandom));
            end else begin
                send_item(swam_pkg::OP_TEXT, pick_symbol());
                random_sent++;
            end
            if (pause_pending && random_sent > 300 && i == span / 2) begin
                drain_results();
                pause_pending = 1'b0;
            end
        end
    endtask

    initial begin : stimulus
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_operation <= swam_pkg::OP_PATTERN;
        s_symbol    <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_report_mode(1'b0);

        // directed opening
        send_item(swam_pkg::OP_TEXT, 8'd65);
        send_item(OP_UNUSED, 8'hFF);
        send_item(swam_pkg::OP_PATTERN, 8'd63);
        send_item(swam_pkg::OP_PATTERN, 8'd125);
        send_item(swam_pkg::OP_PATTERN, 8'd0);
        send_item(swam_pkg::OP_PATTERN, 8'd255);
        send_item(swam_pkg::OP_TEXT, 8'd125);
        send_item(swam_pkg::OP_TEXT, 8'hAA);
        send_item(swam_pkg::OP_PATTERN, 8'd64);
        send_item(swam_pkg::OP_TEXT, 8'd63);
        send_item(swam_pkg::OP_TEXT, 8'd62);
        send_item(swam_pkg::OP_TEXT, 8'd126);
        send_item(swam_pkg::OP_TEXT, 8'd125);
        send_item(swam_pkg::OP_TEXT, 8'd0);
        send_item(swam_pkg::OP_TEXT, 8'd63);
        send_item(swam_pkg::OP_CLEAR, 8'd0);
        send_item(swam_pkg::OP_TEXT, 8'd63);
        send_item(swam_pkg::OP_PATTERN, 8'd64);
        send_item(swam_pkg::OP_TEXT, 8'd64);
        send_item(swam_pkg::OP_TEXT, 8'd64);
        send_item(swam_pkg::OP_TEXT, 8'd100);
        send_item(OP_UNUSED, 8'd0);
        send_item(swam_pkg::OP_CLEAR, 8'h55);

        foreach (pass_modes[ph]) begin
            drain_results();
            write_report_mode(pass_modes[ph]);
            while (random_sent < (ph + 1) * RANDOM_PER_PASS) run_episode();
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : receiver
        int          seg_left;
        int          style;
        logic [15:0] stall_mask;
        int unsigned hold_at [3];
        int          hold_idx;
        hold_at  = '{150, 700, 3000};
        hold_idx = 0;
        seg_left = 0;
        style    = 0;
        stall_mask = 16'hFFFF;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_idx < 3 && board.checked >= hold_at[hold_idx]) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_idx++;
            end
            if (seg_left == 0) begin
                seg_left   = $urandom_range(16, 96);
                style      = $urandom_range(0, 2);
                stall_mask = 16'($urandom) | 16'h0101;
            end
            seg_left--;
            case (style)
                0: m_ready <= 1'b1;
                1: begin
                    m_ready    <= stall_mask[0];
                    stall_mask  = {stall_mask[0], stall_mask[15:1]};
                end
                default: m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.full     = m_window_full;
            seen.is_match = m_is_match;
            seen.start    = m_window_start;
            seen.total    = m_match_total;
            seen.overflow = m_pattern_overflow;
            board.compare_status(seen);
        end
    end

    initial begin : watchdog
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
